>>> hw/rtl/lfs_pkg.sv
package lfs_pkg;

  // Field and register widths
  localparam int COIL_W     = 8;
  localparam int SETPOINT_W = 11;
  localparam int LIMIT_W    = 10;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DUTY_W     = 8;
  localparam int MODE_W     = 3;
  localparam int ERR_W      = 24;
  localparam int ACC_W      = 32;
  localparam int ACC_FRAC   = 8;

  // Datapath widths
  localparam int RAW_W      = 12;                 // setpoint - (ab - cd), integer
  localparam int MIR_W      = 21;                 // mirrored error, Q.8
  localparam int MUL_A_W    = 28;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_W      = 44;
  localparam int SUM_HALF_W = SUM_W / 2;
  localparam int WIDE_W     = 62;
  localparam int DSUM_W     = 47;
  localparam int STEP_W     = 4;

  localparam logic [DUTY_W-1:0]        DUTY_LEFT_MAX   = 8'd105;
  localparam logic [DUTY_W-1:0]        DUTY_RIGHT_MAX  = 8'd131;
  localparam logic signed [ACC_W-1:0]  ACC_RESET       = 32'sd30208;  // 118.0 in Q24.8
  localparam logic [LIMIT_W-1:0]       LIMIT_RESET     = 10'd255;
  localparam logic [GAIN_W-1:0]        IKP_RESET       = 16'd28;
  localparam logic [GAIN_W-1:0]        KD_RESET        = 16'd2816;
  localparam logic [GAIN_W-1:0]        FOLD_GAIN_RESET = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT    = 3'd0,
    CFG_LEFT_LIMIT  = 3'd1,
    CFG_RIGHT_LIMIT = 3'd2,
    CFG_INVERSE_KP  = 3'd3,
    CFG_KD_GAIN     = 3'd4,
    CFG_LOW_FOLD    = 3'd5,
    CFG_HIGH_FOLD   = 3'd6
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRACK       = 3'd0,
    MODE_LEFT_ENTRY  = 3'd1,
    MODE_RIGHT_ENTRY = 3'd2,
    MODE_LEFT_LOCK   = 3'd3,
    MODE_RIGHT_LOCK  = 3'd4
  } steer_mode_t;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_t;

  // Microcode fields
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_E,
    OP_FOLD,
    OP_DIFF1,
    OP_ADD_SUM,
    OP_LOAD_WIDE,
    OP_ADD_WIDE,
    OP_UPD_DACC,
    OP_EMIT
  } alu_op_t;

  typedef enum logic [1:0] {
    MA_FOLD_DIFF,
    MA_D2E,
    MA_SUM_LO,
    MA_SUM_HI
  } mul_a_sel_t;

  typedef enum logic [1:0] {
    MB_FOLD_GAIN,
    MB_KD,
    MB_IKP
  } mul_b_sel_t;

  typedef enum logic {
    JC_NONE,
    JC_NO_FOLD
  } jmp_cond_t;

  typedef struct packed {
    alu_op_t            op;
    mul_a_sel_t         ma;
    mul_b_sel_t         mb;
    jmp_cond_t          jc;
    logic [STEP_W-1:0]  target;
    logic               last;
  } ucode_t;

  // Program addresses
  localparam logic [STEP_W-1:0] STEP_LOAD = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FMUL = 4'd1;
  localparam logic [STEP_W-1:0] STEP_FOLD = 4'd2;
  localparam logic [STEP_W-1:0] STEP_KD   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SUM  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MLO  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MHI  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_ACC  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DACC = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd9;

  function automatic ucode_t uc(input alu_op_t op, input mul_a_sel_t ma,
                                input mul_b_sel_t mb, input jmp_cond_t jc,
                                input logic [STEP_W-1:0] target, input logic last);
    ucode_t w;
    w.op     = op;
    w.ma     = ma;
    w.mb     = mb;
    w.jc     = jc;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // Control store: one word per step, product register loads every step
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      STEP_LOAD: w = uc(OP_LOAD_E,    MA_FOLD_DIFF, MB_FOLD_GAIN, JC_NO_FOLD, STEP_KD,   1'b0);
      STEP_FMUL: w = uc(OP_NOP,       MA_FOLD_DIFF, MB_FOLD_GAIN, JC_NONE,    STEP_LOAD, 1'b0);
      STEP_FOLD: w = uc(OP_FOLD,      MA_D2E,       MB_KD,        JC_NONE,    STEP_LOAD, 1'b0);
      STEP_KD:   w = uc(OP_DIFF1,     MA_D2E,       MB_KD,        JC_NONE,    STEP_LOAD, 1'b0);
      STEP_SUM:  w = uc(OP_ADD_SUM,   MA_SUM_LO,    MB_IKP,       JC_NONE,    STEP_LOAD, 1'b0);
      STEP_MLO:  w = uc(OP_NOP,       MA_SUM_LO,    MB_IKP,       JC_NONE,    STEP_LOAD, 1'b0);
      STEP_MHI:  w = uc(OP_LOAD_WIDE, MA_SUM_HI,    MB_IKP,       JC_NONE,    STEP_LOAD, 1'b0);
      STEP_ACC:  w = uc(OP_ADD_WIDE,  MA_SUM_HI,    MB_IKP,       JC_NONE,    STEP_LOAD, 1'b0);
      STEP_DACC: w = uc(OP_UPD_DACC,  MA_SUM_HI,    MB_IKP,       JC_NONE,    STEP_LOAD, 1'b0);
      STEP_EMIT: w = uc(OP_EMIT,      MA_SUM_HI,    MB_IKP,       JC_NONE,    STEP_LOAD, 1'b1);
      default:   w = uc(OP_NOP,       MA_SUM_HI,    MB_IKP,       JC_NONE,    STEP_LOAD, 1'b1);
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/lfs_if.sv
interface lfs_in_if;
  import lfs_pkg::*;

  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coil_a;
  logic [COIL_W-1:0] coil_b;
  logic [COIL_W-1:0] coil_c;
  logic [COIL_W-1:0] coil_d;
  logic              left_entry_flag;
  logic              right_entry_flag;

  modport source (output valid, coil_a, coil_b, coil_c, coil_d, left_entry_flag,
                  right_entry_flag, input ready);
  modport sink   (input valid, coil_a, coil_b, coil_c, coil_d, left_entry_flag,
                  right_entry_flag, output ready);
endinterface

interface lfs_out_if;
  import lfs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [DUTY_W-1:0]       servo_duty;
  logic [MODE_W-1:0]       steer_mode;
  logic signed [ERR_W-1:0] shaped_error;

  modport source (output valid, servo_duty, steer_mode, shaped_error, input ready);
  modport sink   (input valid, servo_duty, steer_mode, shaped_error, output ready);
endinterface

>>> hw/rtl/line_follow_steering_pd.sv
// Flow: each accepted input word runs the microcode program to a result word; when the error is
//   folded, the program runs two extra steps through the shared multiplier.
// Input: one word at a time, run by the microcode program driving the single 28x17 multiplier;
//   the next word is taken in the cycle the result issues, which waits until the previous result is taken.
// Reset: synchronous active-low rst_n clears the sequencer, output valid, loop state
//   (errors zero, accumulator 118.0, mode track) and loads the register defaults.
module line_follow_steering_pd (
  input  logic                             clk,
  input  logic                             rst_n,
  lfs_in_if.sink                           in_ch,
  lfs_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lfs_pkg::*;

  localparam int INT_W = ACC_W - ACC_FRAC;
  localparam logic signed [INT_W-1:0] DUTY_LO_S = {{(INT_W-DUTY_W){1'b0}}, DUTY_LEFT_MAX};
  localparam logic signed [INT_W-1:0] DUTY_HI_S = {{(INT_W-DUTY_W){1'b0}}, DUTY_RIGHT_MAX};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [SETPOINT_W-1:0] setpoint_r;
  logic [LIMIT_W-1:0]           left_limit_r;
  logic [LIMIT_W-1:0]           right_limit_r;
  logic [GAIN_W-1:0]            inverse_kp_r;
  logic [GAIN_W-1:0]            kd_gain_r;
  logic [GAIN_W-1:0]            low_fold_gain_r;
  logic [GAIN_W-1:0]            high_fold_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r       <= '0;
      left_limit_r     <= LIMIT_RESET;
      right_limit_r    <= LIMIT_RESET;
      inverse_kp_r     <= IKP_RESET;
      kd_gain_r        <= KD_RESET;
      low_fold_gain_r  <= FOLD_GAIN_RESET;
      high_fold_gain_r <= FOLD_GAIN_RESET;
    end else if (cfg_we) begin
      // Drop writes to unused indexes
      unique case (cfg_idx_t'(cfg_index))
        CFG_SETPOINT:    setpoint_r       <= cfg_data[SETPOINT_W-1:0];
        CFG_LEFT_LIMIT:  left_limit_r     <= cfg_data[LIMIT_W-1:0];
        CFG_RIGHT_LIMIT: right_limit_r    <= cfg_data[LIMIT_W-1:0];
        CFG_INVERSE_KP:  inverse_kp_r     <= cfg_data[GAIN_W-1:0];
        CFG_KD_GAIN:     kd_gain_r        <= cfg_data[GAIN_W-1:0];
        CFG_LOW_FOLD:    low_fold_gain_r  <= cfg_data[GAIN_W-1:0];
        CFG_HIGH_FOLD:   high_fold_gain_r <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: step counter over the control store
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  ucode_t            ctrl;
  logic              out_busy;
  logic              finish;
  logic              accept;
  logic              fold_lo_c, fold_hi_c;

  assign ctrl     = ucode_rom(step_r);
  // Hold the last step while the previous result word is still waiting
  assign out_busy = out_valid_r && !out_ch.ready;
  assign finish   = busy_r && ctrl.last && !out_busy;
  // Take the next word in the same cycle the result issues
  assign in_ch.ready = !busy_r || finish;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (accept) begin
      step_nxt = STEP_LOAD;
      busy_nxt = 1'b1;
    end else if (finish) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !ctrl.last) begin
      // Skip the fold steps when the error sits inside both half-limits
      if (ctrl.jc == JC_NO_FOLD && !fold_lo_c && !fold_hi_c) begin
        step_nxt = ctrl.target;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input word capture
  // ---------------------------------------------------------------------------
  logic [COIL_W-1:0] coil_a_r, coil_b_r, coil_c_r, coil_d_r;
  logic              lflag_r, rflag_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      coil_a_r <= in_ch.coil_a;
      coil_b_r <= in_ch.coil_b;
      coil_c_r <= in_ch.coil_c;
      coil_d_r <= in_ch.coil_d;
      lflag_r  <= in_ch.left_entry_flag;
      rflag_r  <= in_ch.right_entry_flag;
    end
  end

  // ---------------------------------------------------------------------------
  // Loop state and datapath registers
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  prev_err_r, prev_prev_err_r;
  logic signed [ACC_W-1:0]  dacc_r, dacc_nxt;
  turn_t                    turn_r, turn_nxt;
  steer_mode_t              mode_reg_r, mode_c;

  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic                     fold_hi_r, fold_hi_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [WIDE_W-1:0] wide_r, wide_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  // Error formation and mirroring from the captured word
  logic [COIL_W:0]          ab_c, cd_c;
  logic signed [RAW_W-1:0]  raw_c;
  logic signed [MIR_W-1:0]  e_q_c, e_m_c;
  logic signed [MIR_W-1:0]  l2_c, r2_c, half_l_c, half_r_c;
  logic                     left_heavy_c;

  assign ab_c  = {1'b0, coil_a_r} + {1'b0, coil_b_r};
  assign cd_c  = {1'b0, coil_c_r} + {1'b0, coil_d_r};
  assign raw_c = {setpoint_r[SETPOINT_W-1], setpoint_r}
               - {{(RAW_W-COIL_W-1){1'b0}}, ab_c}
               + {{(RAW_W-COIL_W-1){1'b0}}, cd_c};
  assign e_q_c = {{(MIR_W-RAW_W-8){raw_c[RAW_W-1]}}, raw_c, 8'b0};

  assign l2_c     = {{(MIR_W-LIMIT_W-9){1'b0}}, left_limit_r, 9'b0};
  assign r2_c     = {{(MIR_W-LIMIT_W-9){1'b0}}, right_limit_r, 9'b0};
  assign half_l_c = {{(MIR_W-LIMIT_W-7){1'b0}}, left_limit_r, 7'b0};
  assign half_r_c = {{(MIR_W-LIMIT_W-7){1'b0}}, right_limit_r, 7'b0};
  assign left_heavy_c = ab_c > cd_c;

  always_comb begin
    e_m_c = e_q_c;
    if (left_heavy_c && mode_reg_r == MODE_LEFT_ENTRY) begin
      e_m_c = -l2_c - e_q_c;
    end else if (!left_heavy_c && mode_reg_r == MODE_RIGHT_ENTRY) begin
      e_m_c = r2_c - e_q_c;
    end
  end

  assign fold_lo_c = e_m_c < -half_l_c;
  assign fold_hi_c = e_m_c > half_r_c;

  // Shared multiplier operands
  logic signed [MUL_A_W-1:0] err_a_c, e1_a_c, e2_a_c, half_l_a_c, half_r_a_c;
  logic signed [MUL_A_W-1:0] mul_a_c;
  logic signed [MUL_B_W-1:0] mul_b_c;

  assign err_a_c    = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign e1_a_c     = {{(MUL_A_W-ERR_W){prev_err_r[ERR_W-1]}}, prev_err_r};
  assign e2_a_c     = {{(MUL_A_W-ERR_W){prev_prev_err_r[ERR_W-1]}}, prev_prev_err_r};
  assign half_l_a_c = {{(MUL_A_W-LIMIT_W-7){1'b0}}, left_limit_r, 7'b0};
  assign half_r_a_c = {{(MUL_A_W-LIMIT_W-7){1'b0}}, right_limit_r, 7'b0};

  always_comb begin
    unique case (ctrl.ma)
      MA_FOLD_DIFF: mul_a_c = fold_hi_r ? half_r_a_c - err_a_c : -half_l_a_c - err_a_c;
      MA_D2E:       mul_a_c = err_a_c - e1_a_c - e1_a_c + e2_a_c;
      // Low half of the PD sum goes in unsigned, high half signed
      MA_SUM_LO:    mul_a_c = {{(MUL_A_W-SUM_HALF_W){1'b0}}, sum_r[SUM_HALF_W-1:0]};
      MA_SUM_HI:    mul_a_c = {{(MUL_A_W-SUM_HALF_W){sum_r[SUM_W-1]}},
                               sum_r[SUM_W-1:SUM_HALF_W]};
      default:      mul_a_c = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.mb)
      MB_FOLD_GAIN: mul_b_c = {1'b0, fold_hi_r ? high_fold_gain_r : low_fold_gain_r};
      MB_KD:        mul_b_c = {1'b0, kd_gain_r};
      MB_IKP:       mul_b_c = {1'b0, inverse_kp_r};
      default:      mul_b_c = '0;
    endcase
  end

  assign prod_nxt = mul_a_c * mul_b_c;

  // Fold: half-limit plus floored gain product, then saturate to 24 bits
  logic signed [PROD_W-1:0] half_sel_c, fold_val_c;
  logic signed [ERR_W-1:0]  fold_sat_c;

  assign half_sel_c = fold_hi_r ? {{(PROD_W-LIMIT_W-7){1'b0}}, right_limit_r, 7'b0}
                                : -{{(PROD_W-LIMIT_W-7){1'b0}}, left_limit_r, 7'b0};
  assign fold_val_c = (prod_r >>> 8) + half_sel_c;

  always_comb begin
    if (&fold_val_c[PROD_W-1:ERR_W-1] || ~|fold_val_c[PROD_W-1:ERR_W-1]) begin
      fold_sat_c = fold_val_c[ERR_W-1:0];
    end else if (fold_val_c[PROD_W-1]) begin
      fold_sat_c = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      fold_sat_c = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  // PD pieces
  logic signed [SUM_W-1:0]  err_s_c, e1_s_c;
  logic signed [WIDE_W-1:0] prod_w_c;

  assign err_s_c  = {{(SUM_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign e1_s_c   = {{(SUM_W-ERR_W){prev_err_r[ERR_W-1]}}, prev_err_r};
  assign prod_w_c = {{(WIDE_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Accumulator update: floor the Q.24 product to Q.8, add, saturate to 32 bits
  logic signed [DSUM_W-1:0] dsum_c;
  logic signed [ACC_W-1:0]  dacc_sat_c;

  assign dsum_c = {{(DSUM_W-ACC_W){dacc_r[ACC_W-1]}}, dacc_r}
                + {wide_r[WIDE_W-1], wide_r[WIDE_W-1:16]};

  always_comb begin
    if (&dsum_c[DSUM_W-1:ACC_W-1] || ~|dsum_c[DSUM_W-1:ACC_W-1]) begin
      dacc_sat_c = dsum_c[ACC_W-1:0];
    end else if (dsum_c[DSUM_W-1]) begin
      dacc_sat_c = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      dacc_sat_c = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // Step datapath
  always_comb begin
    err_nxt     = err_r;
    fold_hi_nxt = fold_hi_r;
    sum_nxt     = sum_r;
    wide_nxt    = wide_r;
    dacc_nxt    = dacc_r;
    if (busy_r) begin
      unique case (ctrl.op)
        OP_LOAD_E: begin
          err_nxt     = {{(ERR_W-MIR_W){e_m_c[MIR_W-1]}}, e_m_c};
          fold_hi_nxt = fold_hi_c;
        end
        OP_FOLD:      err_nxt  = fold_sat_c;
        OP_DIFF1:     sum_nxt  = (err_s_c - e1_s_c) <<< 8;
        OP_ADD_SUM:   sum_nxt  = sum_r + prod_r[SUM_W-1:0];
        OP_LOAD_WIDE: wide_nxt = prod_w_c;
        OP_ADD_WIDE:  wide_nxt = wide_r + (prod_w_c <<< SUM_HALF_W);
        OP_UPD_DACC:  dacc_nxt = dacc_sat_c;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Duty clamp and mode rule
  // ---------------------------------------------------------------------------
  logic signed [INT_W-1:0] duty_int_c;
  logic [DUTY_W-1:0]       pd_duty_c, duty_c;

  assign duty_int_c = dacc_r[ACC_W-1:ACC_FRAC];

  always_comb begin
    if (duty_int_c < DUTY_LO_S) begin
      pd_duty_c = DUTY_LEFT_MAX;
    end else if (duty_int_c > DUTY_HI_S) begin
      pd_duty_c = DUTY_RIGHT_MAX;
    end else begin
      pd_duty_c = duty_int_c[DUTY_W-1:0];
    end
  end

  always_comb begin
    turn_nxt = turn_r;
    mode_c   = MODE_TRACK;
    duty_c   = pd_duty_c;
    if (coil_a_r != '0 && lflag_r) begin
      turn_nxt = TURN_LEFT;
      mode_c   = MODE_LEFT_ENTRY;
    end else if (coil_d_r != '0 && rflag_r) begin
      turn_nxt = TURN_RIGHT;
      mode_c   = MODE_RIGHT_ENTRY;
    end else if (turn_r == TURN_LEFT && coil_a_r == '0) begin
      // Lost the line inside a left curve: lock full left
      mode_c = MODE_LEFT_LOCK;
      duty_c = DUTY_LEFT_MAX;
    end else if (turn_r == TURN_RIGHT && coil_d_r == '0) begin
      mode_c = MODE_RIGHT_LOCK;
      duty_c = DUTY_RIGHT_MAX;
    end else begin
      turn_nxt = TURN_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [DUTY_W-1:0]       duty_out_r;
  steer_mode_t             mode_out_r;
  logic signed [ERR_W-1:0] err_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= STEP_LOAD;
      busy_r          <= 1'b0;
      out_valid_r     <= 1'b0;
      prev_err_r      <= '0;
      prev_prev_err_r <= '0;
      dacc_r          <= ACC_RESET;
      turn_r          <= TURN_NONE;
      mode_reg_r      <= MODE_TRACK;
    end else begin
      step_r      <= step_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      dacc_r      <= dacc_nxt;
      // Advance the loop state once the result word is issued
      if (finish) begin
        prev_prev_err_r <= prev_err_r;
        prev_err_r      <= err_r;
        turn_r          <= turn_nxt;
        mode_reg_r      <= mode_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    err_r     <= err_nxt;
    fold_hi_r <= fold_hi_nxt;
    sum_r     <= sum_nxt;
    wide_r    <= wide_nxt;
    if (busy_r) begin
      prod_r <= prod_nxt;
    end
    if (finish) begin
      duty_out_r <= duty_c;
      mode_out_r <= mode_c;
      err_out_r  <= err_r;
    end
  end

  // Output register parts the result side from the sequencer
  assign out_ch.valid        = out_valid_r;
  assign out_ch.servo_duty   = duty_out_r;
  assign out_ch.steer_mode   = mode_out_r;
  assign out_ch.shaped_error = err_out_r;

endmodule

>>> hw/rtl/lfs_checker.sv
module lfs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lfs_pkg::DUTY_W-1:0]    servo_duty,
  input logic [lfs_pkg::MODE_W-1:0]    steer_mode,
  input logic [lfs_pkg::ERR_W-1:0]     shaped_error
);
  import lfs_pkg::*;

  // Duty always within the servo travel
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (servo_duty >= DUTY_LEFT_MAX && servo_duty <= DUTY_RIGHT_MAX))
    else $error("servo duty out of range");

  // Lock modes drive the matching end stop
  a_lock_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (steer_mode == MODE_LEFT_LOCK || steer_mode == MODE_RIGHT_LOCK)) |->
    (servo_duty == ((steer_mode == MODE_LEFT_LOCK) ? DUTY_LEFT_MAX : DUTY_RIGHT_MAX)))
    else $error("lock mode without end-stop duty");

  // One word at a time: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
    (out_valid && $stable(servo_duty) && $stable(steer_mode) && $stable(shaped_error)))
    else $error("stalled result changed");

endmodule

bind line_follow_steering_pd lfs_checker u_lfs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .servo_duty   (out_ch.servo_duty),
  .steer_mode   (out_ch.steer_mode),
  .shaped_error (out_ch.shaped_error)
);
